@@ rtl/core/aarm_pkg.sv @@
package aarm_pkg;

   localparam int FRAC_BITS_DEF    = 14;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int MAX_STEPS        = 32;

   // Q.30 constants, widths hold 2*pi and headroom
   localparam int QW = 36;
   localparam logic signed [QW-1:0] Q30_ONE     = 36'sd1073741824;
   localparam logic signed [QW-1:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [QW-1:0] Q30_TWO_PI  = 36'sd6746518852;
   localparam logic signed [QW-1:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [QW-1:0] CORDIC_GAIN = 36'sd652032874;

   typedef struct packed {
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic signed [15:0] angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m13;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
      logic signed [15:0] m23;
      logic signed [15:0] m31;
      logic signed [15:0] m32;
      logic signed [15:0] m33;
   } rsp_type;

   // Data handed from cell to cell along the CORDIC chain
   typedef struct packed {
      logic                 neg;
      logic signed [QW-1:0] cx;
      logic signed [QW-1:0] cy;
      logic signed [QW-1:0] cz;
      logic signed [15:0]   x;
      logic signed [15:0]   y;
      logic signed [15:0]   z;
   } cell_type;

   // truncated atan(2^-i) in Q.30
   function automatic logic signed [QW-1:0] atan_q30(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h3243F6A8;  5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;  5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;  5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;  5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;  5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;  5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;  5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;  5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;  5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;  5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;  5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;  5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;  5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;  5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;  5'd29: v = 32'h00000002;
         5'd30: v = 32'h00000001;  default: v = 32'h00000000;
      endcase
      return signed'({4'b0000, v});
   endfunction

endpackage

@@ rtl/core/aarm_cell.sv @@
// One rotation-mode CORDIC iteration, registered
module aarm_cell #(
   parameter int STEP = 0
) (
   input  logic                clock,
   input  logic                en,
   input  aarm_pkg::cell_type  d,
   output aarm_pkg::cell_type  q
);
   import aarm_pkg::*;

   cell_type q_ff, q_in;

   always_comb begin
      q_in = d;
      if (d.cz >= 0) begin
         q_in.cx = d.cx - (d.cy >>> STEP);
         q_in.cy = d.cy + (d.cx >>> STEP);
         q_in.cz = d.cz - atan_q30(5'(STEP));
      end else begin
         q_in.cx = d.cx + (d.cy >>> STEP);
         q_in.cy = d.cy - (d.cx >>> STEP);
         q_in.cz = d.cz + atan_q30(5'(STEP));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;
endmodule

@@ rtl/core/aarm_matrix.sv @@
// Matrix: three registered levels (two multiply), then sums, round, saturate
module aarm_matrix #(
   parameter int FRAC_BITS = 14
) (
   input  logic               clock,
   input  logic               en,
   input  aarm_pkg::cell_type d,
   output aarm_pkg::rsp_type  q
);
   import aarm_pkg::*;

   localparam int PW = QW + 17;
   localparam int FS = 30 - FRAC_BITS;

   // round half up shift of a product by FRAC_BITS
   function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
                                                 input logic signed [15:0] b);
      logic signed [PW-1:0] p;
      p = (PW'(a) * PW'(b)) + (PW'(1) <<< (FRAC_BITS - 1));
      return QW'(p >>> FRAC_BITS);
   endfunction

   function automatic logic signed [15:0] fin(input logic signed [QW+1:0] v);
      logic signed [QW+1:0] r;
      r = (v + ((QW+2)'(1) <<< (FS - 1))) >>> FS;
      if (r > 32767) return 16'sh7fff;
      if (r < -32768) return 16'sh8000;
      return r[15:0];
   endfunction

   // level 1: c, s, t
   logic signed [QW-1:0] c1_ff, s1_ff, t1_ff;
   logic signed [15:0]   x1_ff, y1_ff, z1_ff;
   // level 2: t*axis, s*axis
   logic signed [QW-1:0] c2_ff, tx2_ff, ty2_ff, tz2_ff, sx2_ff, sy2_ff, sz2_ff;
   logic signed [15:0]   x2_ff, y2_ff, z2_ff;
   // level 3: second products
   logic signed [QW-1:0] c3_ff, sx3_ff, sy3_ff, sz3_ff;
   logic signed [QW-1:0] xx3_ff, xy3_ff, xz3_ff, yy3_ff, yz3_ff, zz3_ff;
   rsp_type              q_ff, q_in;

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff  <= d.neg ? -d.cx : d.cx;
         s1_ff  <= d.neg ? -d.cy : d.cy;
         t1_ff  <= d.neg ? Q30_ONE + d.cx : Q30_ONE - d.cx;
         x1_ff  <= d.x;
         y1_ff  <= d.y;
         z1_ff  <= d.z;
         c2_ff  <= c1_ff;
         tx2_ff <= mulq(t1_ff, x1_ff);
         ty2_ff <= mulq(t1_ff, y1_ff);
         tz2_ff <= mulq(t1_ff, z1_ff);
         sx2_ff <= mulq(s1_ff, x1_ff);
         sy2_ff <= mulq(s1_ff, y1_ff);
         sz2_ff <= mulq(s1_ff, z1_ff);
         x2_ff  <= x1_ff;
         y2_ff  <= y1_ff;
         z2_ff  <= z1_ff;
         c3_ff  <= c2_ff;
         sx3_ff <= sx2_ff;
         sy3_ff <= sy2_ff;
         sz3_ff <= sz2_ff;
         xx3_ff <= mulq(tx2_ff, x2_ff);
         xy3_ff <= mulq(tx2_ff, y2_ff);
         xz3_ff <= mulq(tx2_ff, z2_ff);
         yy3_ff <= mulq(ty2_ff, y2_ff);
         yz3_ff <= mulq(ty2_ff, z2_ff);
         zz3_ff <= mulq(tz2_ff, z2_ff);
         q_ff   <= q_in;
      end
   end

   always_comb begin
      q_in.m11 = fin((QW+2)'(xx3_ff) + (QW+2)'(c3_ff));
      q_in.m12 = fin((QW+2)'(xy3_ff) + (QW+2)'(sz3_ff));
      q_in.m13 = fin((QW+2)'(xz3_ff) - (QW+2)'(sy3_ff));
      q_in.m21 = fin((QW+2)'(xy3_ff) - (QW+2)'(sz3_ff));
      q_in.m22 = fin((QW+2)'(yy3_ff) + (QW+2)'(c3_ff));
      q_in.m23 = fin((QW+2)'(yz3_ff) + (QW+2)'(sx3_ff));
      q_in.m31 = fin((QW+2)'(xz3_ff) + (QW+2)'(sy3_ff));
      q_in.m32 = fin((QW+2)'(yz3_ff) - (QW+2)'(sx3_ff));
      q_in.m33 = fin((QW+2)'(zz3_ff) + (QW+2)'(c3_ff));
   end

   assign q = q_ff;
endmodule

@@ rtl/core/axis_angle_to_rotation_matrix.sv @@
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | req_data (axis, angle)
// rsp     | out       | rsp_valid / rsp_ready | rsp_data (m11..m33)
//
// One item per cycle unless stalled; stages (CORDIC steps capped at 32):
// one range-reduction register, one cell per CORDIC iteration, three matrix
// level registers, one output register.
// The whole pipeline advances together; it stalls only when the output
// register holds an item that is not taken.
// Synchronous reset clears the valid bits only.
module axis_angle_to_rotation_matrix #(
   parameter int FRAC_BITS    = aarm_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  aarm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output aarm_pkg::rsp_type rsp_data
);
   import aarm_pkg::*;

   localparam int NS  = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
   localparam int LAT = NS + 5;

   logic            en;
   logic [LAT-1:0]  vld_ff, vld_in;
   cell_type        red_ff, red_in;
   cell_type        chain [NS+1];

   // pipeline moves whenever the last stage is empty or taken
   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAT-1];

   always_comb begin
      vld_in = {vld_ff[LAT-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // angle range reduction into [-pi/2, pi/2]
   always_comb begin
      logic signed [QW-1:0] a;
      a = QW'(req_data.angle) <<< 18;
      if (a > Q30_PI) a = a - Q30_TWO_PI;
      if (a < -Q30_PI) a = a + Q30_TWO_PI;
      red_in.neg = 1'b0;
      if (a > Q30_HALF_PI) begin
         a = a - Q30_PI;
         red_in.neg = 1'b1;
      end else if (a < -Q30_HALF_PI) begin
         a = a + Q30_PI;
         red_in.neg = 1'b1;
      end
      red_in.cx = CORDIC_GAIN;
      red_in.cy = '0;
      red_in.cz = a;
      red_in.x  = req_data.axis_x;
      red_in.y  = req_data.axis_y;
      red_in.z  = req_data.axis_z;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff <= red_in;
      end
   end

   assign chain[0] = red_ff;

   for (genvar g = 0; g < NS; g++) begin : g_cell
      aarm_cell #(.STEP(g)) u_cell (
         .clock (clock),
         .en    (en),
         .d     (chain[g]),
         .q     (chain[g+1])
      );
   end

   aarm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
      .clock (clock),
      .en    (en),
      .d     (chain[NS]),
      .q     (rsp_data)
   );

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data));
   a_ready_tie : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready);
   a_pipe_move : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0]);
endmodule

@@ tb/axis_angle_to_rotation_matrix_test.sv @@
`timescale 1ns / 100ps

module axis_angle_to_rotation_matrix_test;
   import aarm_pkg::*;

   localparam int FRAC      = 14;
   localparam int STEPS     = 16;
   localparam int LATENCY   = STEPS + 6;
   localparam int N_RANDOM  = 1500;
   localparam int WD_LIMIT  = 20000;
   localparam int HOLD_LEN  = 200;

   typedef logic signed [63:0] s64;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_items[$];
   rsp_type expected_matrices[$];
   int      mismatches = 0;
   int      sent = 0;
   int      received = 0;
   bit      stimulus_done = 0;
   bit      hold_off = 0;

   axis_angle_to_rotation_matrix i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // floor shift and round-half-up shift
   function automatic s64 floor_shift(s64 v, int s);
      return v >>> s;
   endfunction

   function automatic s64 round_shift(s64 v, int s);
      if (s == 0) return v;
      return (v + (s64'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic s64 mul_q(s64 q30, s64 qf);
      return round_shift(q30 * qf, FRAC);
   endfunction

   function automatic logic signed [15:0] to_entry(s64 q30);
      s64 v;
      v = round_shift(q30, 30 - FRAC);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic s64 atan_entry(int i);
      logic [31:0] t[32];
      t = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
            32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
            32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
            32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
            32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
            32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
            32'h00000001, 32'h00000000};
      return s64'(t[i]);
   endfunction

   // rotation matrix of one axis-angle item
   function automatic rsp_type rotation_matrix(req_type r);
      s64 x, y, z, a, cx, cy, cz, dx, dy, c, s, t, tx, ty, tz;
      bit flip;
      rsp_type m;
      x = r.axis_x; y = r.axis_y; z = r.axis_z;
      a = s64'(r.angle) <<< 18;
      flip = 0;
      if (a > 64'sd3373259426) a -= 64'sd6746518852;
      if (a < -64'sd3373259426) a += 64'sd6746518852;
      if (a > 64'sd1686629713) begin
         a -= 64'sd3373259426; flip = 1;
      end else if (a < -64'sd1686629713) begin
         a += 64'sd3373259426; flip = 1;
      end
      cx = 64'sd652032874; cy = 0; cz = a;
      for (int i = 0; i < STEPS && i < 32; i++) begin
         dx = floor_shift(cy, i);
         dy = floor_shift(cx, i);
         if (cz >= 0) begin
            cx -= dx; cy += dy; cz -= atan_entry(i);
         end else begin
            cx += dx; cy -= dy; cz += atan_entry(i);
         end
      end
      c = flip ? -cx : cx;
      s = flip ? -cy : cy;
      t = 64'sd1073741824 - c;
      tx = mul_q(t, x); ty = mul_q(t, y); tz = mul_q(t, z);
      m.m11 = to_entry(mul_q(tx, x) + c);
      m.m12 = to_entry(mul_q(tx, y) + mul_q(s, z));
      m.m13 = to_entry(mul_q(tx, z) - mul_q(s, y));
      m.m21 = to_entry(mul_q(tx, y) - mul_q(s, z));
      m.m22 = to_entry(mul_q(ty, y) + c);
      m.m23 = to_entry(mul_q(ty, z) + mul_q(s, x));
      m.m31 = to_entry(mul_q(tx, z) + mul_q(s, y));
      m.m32 = to_entry(mul_q(ty, z) - mul_q(s, x));
      m.m33 = to_entry(mul_q(tz, z) + c);
      return m;
   endfunction

   function automatic logic signed [15:0] axis_value();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return -16'sd32768;
         3: return 16'($urandom);
         default: return 16'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // pending item queue: directed corners then random items
   initial begin
      req_type r;
      logic signed [15:0] axes[6];
      logic signed [15:0] angles[8];
      axes = '{16'sd16384, -16'sd16384, 16'sd0, -16'sd32768, 16'sd32767, 16'sd11585};
      // zero, pi, -pi, just above pi, pi/2, extremes, small
      angles = '{16'sd0, 16'sd12868, -16'sd12868, 16'sd12869, 16'sd6434,
                 16'sd32767, -16'sd32768, 16'sd1};
      for (int i = 0; i < 24; i++) begin
         r.axis_x = axes[i % 6];
         r.axis_y = axes[(i / 6 + i) % 6];
         r.axis_z = axes[(i * 5 + 1) % 6];
         r.angle  = angles[i % 8];
         pending_items.push_back(r);
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         r.axis_x = axis_value();
         r.axis_y = axis_value();
         r.axis_z = axis_value();
         r.angle  = 16'($urandom);
         pending_items.push_back(r);
      end
   end

   // driver
   int send_wait = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         // hold item
      end else begin
         if (req_valid) begin
            expected_matrices.push_back(rotation_matrix(req_data));
            sent++;
         end
         if (send_wait > 0) begin
            send_wait <= send_wait - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_data  <= pending_items.pop_front();
            req_valid <= 1'b1;
            send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
         end else begin
            req_valid <= 1'b0;
            stimulus_done <= 1'b1;
         end
      end
   end

   // long receiver hold-off after a few hundred items
   initial begin
      wait (sent >= 300);
      hold_off = 1;
      repeat (HOLD_LEN) @(posedge clock);
      hold_off = 0;
   end

   // monitor and checker
   int recv_wait = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            received++;
            if (expected_matrices.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", rsp_data);
            end else begin
               want = expected_matrices.pop_front();
               if (want !== rsp_data) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch on item %0d: expected %h actual %h",
                              received, want, rsp_data);
               end
            end
         end
         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_valid && rsp_ready)
               recv_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
         end
      end
   end

   // watchdog on cycles without any accepted item
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("timeout");
         $display("Test completed with failures");
         $finish;
      end
   end

   // reset and end of run
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && !req_valid && expected_matrices.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("%0d axis-angle items checked, including pi folds, wraps and saturation",
               received);
      $display("%0d mismatches, with random stalls and one long output hold-off",
               mismatches);
      if (mismatches == 0 && expected_matrices.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
